/* hdl/swmf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package swmf_pkg;

    // Fixed widths of the port fields
    localparam int SAMPLE_W = 16;
    localparam int RADIUS_W = 6;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 6'd1;

    // Defaults for the top level parameters
    localparam int MAX_RADIUS_DEF  = 63;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_LINE_DEF    = 8192;

    // Controller to datapath
    typedef struct packed {
        logic take;      // accept a beat: store sample, capture line state
        logic setup;     // prepare the scan for one output position
        logic scan;      // read one store entry and step the scan
        logic advance;   // result taken, step to the next position
    } swmf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic emit;       // the offered beat produces at least one result
        logic scan_last;  // the read issued this cycle is the newest sample
        logic more;       // flush still owes results
    } swmf_status_t;

endpackage
`default_nettype wire

/* hdl/swmf_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module swmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 127
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* hdl/swmf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module swmf_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output swmf_pkg::swmf_cmd_t        cmd,
    input  wire swmf_pkg::swmf_status_t st
);
    import swmf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FOLD  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence take, scan per output position, and result handoff
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (st.emit)
                    begin
                        state_next = S_SETUP;
                    end
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.scan_last)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    cmd.advance = 1'b1;
                    state_next  = st.more ? S_SETUP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hdl/swmf_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module swmf_datapath #(
    parameter int MAX_RADIUS  = swmf_pkg::MAX_RADIUS_DEF,
    parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_LINE    = swmf_pkg::MAX_LINE_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [swmf_pkg::RADIUS_W-1:0] cfg_data,
    input  wire logic [swmf_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                          line_end,
    output logic      [swmf_pkg::SAMPLE_W-1:0] result,
    output logic                               last_of_line,
    input  wire swmf_pkg::swmf_cmd_t           cmd,
    output swmf_pkg::swmf_status_t             st
);
    import swmf_pkg::*;

    localparam int DEPTH  = 2 * MAX_RADIUS + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
    localparam int POS_W  = $clog2(MAX_LINE);

    logic [RADIUS_W-1:0]    radius_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [ADDR_W-1:0]      wptr_reg;
    logic [POS_W-1:0]       newest_reg;
    logic [ADDR_W-1:0]      base_reg;
    logic [RAD_W-1:0]       r_reg;
    logic [RAD_W-1:0]       d_reg;
    logic                   flush_reg;
    logic [ADDR_W-1:0]      back_reg;
    logic [ADDR_W-1:0]      raddr_reg;
    logic                   rd_valid_reg;
    logic [SAMPLE_BITS-1:0] acc_reg;

    logic [RAD_W-1:0]       r_eff;
    logic                   is_last;
    logic [RAD_W-1:0]       d_first;
    logic [ADDR_W-1:0]      span;
    logic [ADDR_W-1:0]      back_first;
    logic [ADDR_W:0]        start_wide;
    logic [ADDR_W-1:0]      start_addr;
    logic [SAMPLE_BITS-1:0] rdata;

    // Clamp the radius to the store size
    assign r_eff = (32'(radius_reg) > 32'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                       : RAD_W'(radius_reg);

    // Force line end on an overlong line
    assign is_last = line_end || (32'(pos_reg) >= 32'(MAX_LINE - 1));

    // Flush starts at the oldest position still owed; otherwise one output r back
    assign d_first = (is_last && (32'(pos_reg) < 32'(r_eff))) ? RAD_W'(pos_reg) : r_eff;

    assign st.emit = is_last || (32'(pos_reg) >= 32'(r_eff));

    // Window of position newest-d reaches back d+r, clipped at line start
    assign span       = ADDR_W'(d_reg) + ADDR_W'(r_reg);
    assign back_first = (32'(newest_reg) < 32'(span)) ? ADDR_W'(newest_reg) : span;
    assign start_wide = {1'b0, base_reg} + (ADDR_W + 1)'(DEPTH) - {1'b0, back_first};
    assign start_addr = (base_reg >= back_first) ? (base_reg - back_first)
                                                 : ADDR_W'(start_wide);

    assign st.scan_last = (back_reg == '0);
    assign st.more      = flush_reg && (d_reg != '0);

    swmf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.take),
        .waddr (wptr_reg),
        .wdata (sample[SAMPLE_BITS-1:0]),
        .raddr (raddr_reg),
        .rdata (rdata)
    );

    // Radius register and line position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= RADIUS_RESET;
            pos_reg      <= '0;
            wptr_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                radius_reg <= cfg_data;
            end
            if (cmd.take)
            begin
                if (is_last)
                begin
                    pos_reg  <= '0;
                    wptr_reg <= '0;
                end
                else
                begin
                    pos_reg  <= pos_reg + 1'b1;
                    wptr_reg <= (wptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
                end
            end
            rd_valid_reg <= cmd.scan;
        end
    end

    // Capture the beat, run the scan, fold the minimum
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            newest_reg <= pos_reg;
            base_reg   <= wptr_reg;
            r_reg      <= r_eff;
            d_reg      <= d_first;
            flush_reg  <= is_last;
        end
        if (cmd.setup)
        begin
            back_reg  <= back_first;
            raddr_reg <= start_addr;
        end
        if (cmd.scan)
        begin
            back_reg  <= back_reg - 1'b1;
            raddr_reg <= (raddr_reg == ADDR_W'(DEPTH - 1)) ? '0 : raddr_reg + 1'b1;
        end
        if (cmd.advance)
        begin
            d_reg <= d_reg - 1'b1;
        end
        if (cmd.setup)
        begin
            acc_reg <= '1;
        end
        else if (rd_valid_reg && (rdata < acc_reg))
        begin
            acc_reg <= rdata;
        end
    end

    assign result       = SAMPLE_W'(acc_reg);
    assign last_of_line = flush_reg && (d_reg == '0);

endmodule
`default_nettype wire

/* hdl/sliding_window_min_filter.sv */
`timescale 1ns / 1ps
`default_nettype none
// Running minimum (1-D grayscale erosion) over one image line. Each beat on the
// input carries a sample and a line_end flag; for position p the block returns
// the minimum of positions p-radius..p+radius, clipped to the line, once sample
// p+radius has arrived, and on the line's last sample it returns every result
// still owed, the final one marked with last_of_line. The radius register
// (reset 1, clamped to MAX_RADIUS) is written through the cfg channel; the
// user must write it only while the block is idle, which the block does not
// enforce. One item is processed at a time: the scan reads the sample store
// one entry per cycle through its single read port, then the minimum is
// folded and offered on the output, where an output stall holds it; the
// input is stalled until all results of a beat are taken, and a beat that
// produces no result leaves the block idle and ready for the next beat.
module sliding_window_min_filter #(
    parameter int MAX_RADIUS  = swmf_pkg::MAX_RADIUS_DEF,
    parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_LINE    = swmf_pkg::MAX_LINE_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [swmf_pkg::RADIUS_W-1:0] cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [swmf_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                          line_end,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [swmf_pkg::SAMPLE_W-1:0] result,
    output logic                               last_of_line
);
    import swmf_pkg::*;

    swmf_cmd_t    cmd;
    swmf_status_t st;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    swmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .st        (st)
    );

    swmf_datapath #(
        .MAX_RADIUS  (MAX_RADIUS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_LINE    (MAX_LINE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .sample       (sample),
        .line_end     (line_end),
        .result       (result),
        .last_of_line (last_of_line),
        .cmd          (cmd),
        .st           (st)
    );

endmodule
`default_nettype wire
